// File: sv/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg - shared types and codes for the Roman calendar date unit
// Field widths, result codes, month names and the per-stage record that
// carries the calendar part of a date down the pipeline.
// ----------------------------------------------------------------------------
package rcd_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MON_W   = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned CY_W    = 12;  // year width once range checked (<= 3999)
	localparam int unsigned EM_W    = 3;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned REF_W   = 2;
	localparam int unsigned HOL_W   = 2;

	localparam logic [YEAR_W-1:0] YEAR_MIN  = 14'd1;
	localparam logic [YEAR_W-1:0] YEAR_MAX  = 14'd3999;
	localparam logic [YEAR_W-1:0] GREG_LAST = 14'd1582;

	localparam logic [HOL_W-1:0] HOL_NONE   = 2'd0;
	localparam logic [HOL_W-1:0] HOL_EASTER = 2'd1;
	localparam logic [HOL_W-1:0] HOL_XMAS   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_KAL    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NONES  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_IDES   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_PRIDIE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_ANTE   = 3'd4;

	localparam logic [REF_W-1:0] REF_NONE  = 2'd0;
	localparam logic [REF_W-1:0] REF_NONES = 2'd1;
	localparam logic [REF_W-1:0] REF_IDES  = 2'd2;
	localparam logic [REF_W-1:0] REF_KAL   = 2'd3;

	localparam logic [MON_W-1:0] MON_JAN = 4'd0;
	localparam logic [MON_W-1:0] MON_FEB = 4'd1;
	localparam logic [MON_W-1:0] MON_MAR = 4'd2;
	localparam logic [MON_W-1:0] MON_APR = 4'd3;
	localparam logic [MON_W-1:0] MON_MAY = 4'd4;
	localparam logic [MON_W-1:0] MON_JUN = 4'd5;
	localparam logic [MON_W-1:0] MON_JUL = 4'd6;
	localparam logic [MON_W-1:0] MON_SEP = 4'd8;
	localparam logic [MON_W-1:0] MON_OCT = 4'd9;
	localparam logic [MON_W-1:0] MON_NOV = 4'd10;
	localparam logic [MON_W-1:0] MON_DEC = 4'd11;
	localparam logic [MON_W-1:0] MON_NUM = 4'd12;

	localparam logic [DAY_W-1:0] XMAS_DAY = 5'd25;

	localparam logic [EM_W-1:0] EM_MAR = 3'd3;
	localparam logic [EM_W-1:0] EM_APR = 3'd4;

	typedef struct packed {
		logic              ok;      // year in range
		logic              greg;    // year after the Gregorian switch
		logic [DAY_W-1:0]  day;     // day as given, for the holiday test
		logic [MON_W-1:0]  month;   // normalized month
		logic [KIND_W-1:0] kind;
		logic [REF_W-1:0]  refc;
		logic [MON_W-1:0]  rmonth;
		logic [DAY_W-1:0]  count;
	} cal_t;

endpackage

// File: sv/roman_calendar_date_unit.sv
// ----------------------------------------------------------------------------
// roman_calendar_date_unit - Gregorian date to Roman calendar form
// A date taken at a clock edge passes stage registers s1 to s9 on its way to the result ports.
// Throughput: one date per cycle; busy stays low and the pipeline never stalls.
// The depth is set by the Easter computus chain of constant divisions.
// Reset clears only the valid bits of the stages; payload is not reset.
// ----------------------------------------------------------------------------
module roman_calendar_date_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [rcd_pkg::DAY_W-1:0]   day,
	input  logic [rcd_pkg::MON_W-1:0]   month,
	input  logic [rcd_pkg::YEAR_W-1:0]  year,
	output logic                        done,
	output logic                        valid_res,
	output logic [rcd_pkg::HOL_W-1:0]   holiday,
	output logic [rcd_pkg::KIND_W-1:0]  day_kind,
	output logic [rcd_pkg::REF_W-1:0]   reference,
	output logic [rcd_pkg::MON_W-1:0]   reference_month,
	output logic [rcd_pkg::DAY_W-1:0]   day_count,
	output logic [rcd_pkg::EM_W-1:0]    easter_month,
	output logic [rcd_pkg::DAY_W-1:0]   easter_day
);
	import rcd_pkg::*;

	localparam logic [11:0] RCP_25 = 12'd2621;  // 2^16 / 25, rounded down

	assign busy = 1'b0;

	// valid bits per stage
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	// stage 1: range check, month wrap
	logic [DAY_W-1:0] day_s1;
	logic [MON_W-1:0] mon_s1;
	logic             ok_s1;
	logic             greg_s1;
	logic [CY_W-1:0]  y_s1;
	logic             ok_in;

	assign ok_in = (year >= YEAR_MIN) && (year <= YEAR_MAX);

	always_ff @(posedge clk) begin
		day_s1  <= day;
		mon_s1  <= (month >= MON_NUM) ? month - MON_NUM : month;
		ok_s1   <= ok_in;
		greg_s1 <= (year > GREG_LAST);
		y_s1    <= ok_in ? year[CY_W-1:0] : '0;
	end

	// stage 2: leap year; y / 100 equals (y / 4) / 25 when 4 divides y
	logic [9:0]  x25;
	logic [21:0] p25;
	logic [5:0]  q25a;
	logic [9:0]  r25a;
	logic        r25_hi;
	logic        r25_zero;
	logic [5:0]  q25;
	logic        leap2;

	always_comb begin
		x25      = y_s1[CY_W-1:2];
		p25      = 22'(x25) * 22'(RCP_25);
		q25a     = p25[21:16];
		r25a     = x25 - 10'(q25a) * 10'd25;
		r25_hi   = (r25a >= 10'd25);
		r25_zero = r25_hi ? (r25a == 10'd25) : (r25a == 10'd0);
		q25      = q25a + {5'd0, r25_hi};
		leap2    = (y_s1[1:0] == 2'd0) && (!r25_zero || (q25[1:0] == 2'd0));
	end

	logic [DAY_W-1:0] day_s2;
	logic [MON_W-1:0] mon_s2;
	logic             ok_s2;
	logic             greg_s2;
	logic             leap_s2;

	always_ff @(posedge clk) begin
		day_s2  <= day_s1;
		mon_s2  <= mon_s1;
		ok_s2   <= ok_s1;
		greg_s2 <= greg_s1;
		leap_s2 <= leap2;
	end

	// stage 3: Roman form of the date
	logic [DAY_W-1:0] dim;
	logic [DAY_W-1:0] dc;
	logic             long_nones;
	logic [DAY_W-1:0] nones;
	logic [DAY_W-1:0] ides;
	cal_t             cal3;

	always_comb begin
		unique case (mon_s2)
			MON_FEB:                         dim = leap_s2 ? 5'd29 : 5'd28;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: dim = 5'd30;
			default:                         dim = 5'd31;
		endcase
		dc         = (day_s2 > dim) ? dim : day_s2;
		long_nones = (mon_s2 == MON_MAR) || (mon_s2 == MON_MAY) ||
		             (mon_s2 == MON_JUL) || (mon_s2 == MON_OCT);
		nones      = long_nones ? 5'd7 : 5'd5;
		ides       = long_nones ? 5'd15 : 5'd13;

		cal3.ok     = ok_s2;
		cal3.greg   = greg_s2;
		cal3.day    = day_s2;
		cal3.month  = mon_s2;
		cal3.kind   = KIND_KAL;
		cal3.refc   = REF_NONE;
		cal3.rmonth = mon_s2;
		cal3.count  = '0;

		priority if (dc == 5'd1) begin
			cal3.kind = KIND_KAL;
		end else if (dc < nones) begin
			cal3.count = nones - dc + 5'd1;
			cal3.refc  = REF_NONES;
		end else if (dc == nones) begin
			cal3.kind = KIND_NONES;
		end else if (dc < ides) begin
			cal3.count = ides - dc + 5'd1;
			cal3.refc  = REF_IDES;
		end else if (dc == ides) begin
			cal3.kind = KIND_IDES;
		end else begin
			cal3.count  = dim - dc + 5'd2;
			cal3.refc   = REF_KAL;
			cal3.rmonth = (mon_s2 == MON_DEC) ? MON_JAN : mon_s2 + 4'd1;
		end

		if (cal3.refc != REF_NONE) begin
			cal3.kind = (cal3.count == 5'd2) ? KIND_PRIDIE : KIND_ANTE;
		end
	end

	// calendar record waits for the computus
	cal_t cal_s3, cal_s4, cal_s5, cal_s6, cal_s7, cal_s8;

	always_ff @(posedge clk) begin
		cal_s3 <= cal3;
		cal_s4 <= cal_s3;
		cal_s5 <= cal_s4;
		cal_s6 <= cal_s5;
		cal_s7 <= cal_s6;
		cal_s8 <= cal_s7;
	end

	logic [EM_W-1:0]  em_s8;
	logic [DAY_W-1:0] ed_s8;

	rcd_easter u_easter (
		.clk (clk),
		.y   (y_s1),
		.em  (em_s8),
		.ed  (ed_s8)
	);

	// stage 9: holiday and output register; out-of-range years read as zero
	logic [HOL_W-1:0] hol8;

	always_comb begin
		priority if (cal_s8.greg && (cal_s8.day == ed_s8) &&
		             (cal_s8.month + 4'd1 == {1'b0, em_s8})) begin
			hol8 = HOL_EASTER;
		end else if ((cal_s8.day == XMAS_DAY) && (cal_s8.month == MON_DEC)) begin
			hol8 = HOL_XMAS;
		end else begin
			hol8 = HOL_NONE;
		end
	end

	logic             ok_s9;
	logic [HOL_W-1:0] hol_s9;
	logic [KIND_W-1:0] kind_s9;
	logic [REF_W-1:0] refc_s9;
	logic [MON_W-1:0] rmon_s9;
	logic [DAY_W-1:0] count_s9;
	logic [EM_W-1:0]  em_s9;
	logic [DAY_W-1:0] ed_s9;

	always_ff @(posedge clk) begin
		ok_s9 <= cal_s8.ok;
		if (cal_s8.ok) begin
			hol_s9   <= hol8;
			kind_s9  <= cal_s8.kind;
			refc_s9  <= cal_s8.refc;
			rmon_s9  <= cal_s8.rmonth;
			count_s9 <= cal_s8.count;
			em_s9    <= em_s8;
			ed_s9    <= ed_s8;
		end else begin
			hol_s9   <= HOL_NONE;
			kind_s9  <= KIND_KAL;
			refc_s9  <= REF_NONE;
			rmon_s9  <= MON_JAN;
			count_s9 <= '0;
			em_s9    <= '0;
			ed_s9    <= '0;
		end
	end

	assign done            = vld_s9;
	assign valid_res       = ok_s9;
	assign holiday         = hol_s9;
	assign day_kind        = kind_s9;
	assign reference       = refc_s9;
	assign reference_month = rmon_s9;
	assign day_count       = count_s9;
	assign easter_month    = em_s9;
	assign easter_day      = ed_s9;

	// Easter always falls between March 22 and April 25
	a_easter_window: assert property (@(posedge clk) disable iff (!arst_n)
		done && valid_res |->
			((easter_month == EM_MAR) && (easter_day >= 5'd22)) ||
			((easter_month == EM_APR) && (easter_day <= 5'd25)))
		else $error("easter date outside March 22 .. April 25");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !valid_res |->
			(holiday == HOL_NONE) && (day_kind == KIND_KAL) && (reference == REF_NONE) &&
			(reference_month == MON_JAN) && (day_count == 5'd0) &&
			(easter_month == 3'd0) && (easter_day == 5'd0))
		else $error("out-of-range year with nonzero result fields");

	a_counted_kind: assert property (@(posedge clk) disable iff (!arst_n)
		done && valid_res && (reference != REF_NONE) |->
			(day_count >= 5'd2) &&
			((day_kind == KIND_PRIDIE) == (day_count == 5'd2)) &&
			((day_kind == KIND_PRIDIE) || (day_kind == KIND_ANTE)))
		else $error("counted day with inconsistent kind or count");

	a_named_day: assert property (@(posedge clk) disable iff (!arst_n)
		done && valid_res && (reference == REF_NONE) |->
			(day_count == 5'd0) && (day_kind != KIND_PRIDIE) && (day_kind != KIND_ANTE))
		else $error("kalends, nones or ides day carries a count");

	a_easter_greg: assert property (@(posedge clk) disable iff (!arst_n)
		done && (holiday == HOL_EASTER) |-> valid_res && (reference_month != MON_DEC))
		else $error("easter holiday flagged outside a valid spring date");

endmodule

// File: sv/rcd_easter.sv
// ----------------------------------------------------------------------------
// rcd_easter - Gregorian Easter computus pipeline
// Seven register stages from year to Easter month and day. Each division
// by 100, 19, 3, 30 or 7 is a reciprocal multiply that underestimates by
// less than one, followed by a single compare-and-subtract correction.
// ----------------------------------------------------------------------------
module rcd_easter (
	input  logic                      clk,
	input  logic [rcd_pkg::CY_W-1:0]  y,
	output logic [rcd_pkg::EM_W-1:0]  em,
	output logic [rcd_pkg::DAY_W-1:0] ed
);
	import rcd_pkg::*;

	localparam logic [9:0]  RCP_100 = 10'd655;    // 2^16 / 100, rounded down
	localparam logic [11:0] RCP_19  = 12'd3449;   // 2^16 / 19, rounded down
	localparam logic [4:0]  RCP_3   = 5'd21;      // 2^6 / 3, rounded down
	localparam logic [4:0]  RCP_30  = 5'd17;      // 2^9 / 30, rounded down
	localparam logic [3:0]  RCP_7   = 4'd9;       // 2^6 / 7, rounded down
	localparam logic [8:0]  M_LIM   = 9'd451;
	localparam logic [7:0]  S_OFS   = 8'd114;
	localparam logic [7:0]  S_APR   = 8'd124;     // 4 * 31
	localparam logic [7:0]  S_MAR   = 8'd93;      // 3 * 31

	// stage 2: a = y mod 19, b = y / 100, c = y mod 100
	logic [21:0] p100;
	logic [5:0]  bq0;
	logic [11:0] br0;
	logic [23:0] p19;
	logic [7:0]  aq0;
	logic [11:0] ar0;
	logic [4:0]  a_s2;
	logic [5:0]  b_s2;
	logic [6:0]  c_s2;

	always_comb begin
		p100 = 22'(y) * 22'(RCP_100);
		bq0  = p100[21:16];
		br0  = y - 12'(bq0) * 12'd100;
		p19  = 24'(y) * 24'(RCP_19);
		aq0  = p19[23:16];
		ar0  = y - 12'(aq0) * 12'd19;
	end

	always_ff @(posedge clk) begin
		if (br0 >= 12'd100) begin
			b_s2 <= bq0 + 6'd1;
			c_s2 <= 7'(br0 - 12'd100);
		end else begin
			b_s2 <= bq0;
			c_s2 <= 7'(br0);
		end
		a_s2 <= (ar0 >= 12'd19) ? 5'(ar0 - 12'd19) : 5'(ar0);
	end

	// stage 3: d, e, g, i, k
	logic       f3;
	logic [5:0] gx;
	logic [10:0] gp;
	logic [3:0] gq0;
	logic [5:0] gr0;
	logic [3:0] d_s3;
	logic [1:0] e_s3;
	logic [3:0] g_s3;
	logic [4:0] i_s3;
	logic [1:0] k_s3;
	logic [4:0] a_s3;
	logic [5:0] b_s3;

	always_comb begin
		f3  = (b_s2 >= 6'd17);  // (b + 8) / 25 is 0 or 1 over the year range
		gx  = b_s2 - {5'd0, f3} + 6'd1;
		gp  = 11'(gx) * 11'(RCP_3);
		gq0 = gp[9:6];
		gr0 = gx - 6'(gq0) * 6'd3;
	end

	always_ff @(posedge clk) begin
		g_s3 <= (gr0 >= 6'd3) ? gq0 + 4'd1 : gq0;
		d_s3 <= b_s2[5:2];
		e_s3 <= b_s2[1:0];
		i_s3 <= c_s2[6:2];
		k_s3 <= c_s2[1:0];
		a_s3 <= a_s2;
		b_s3 <= b_s2;
	end

	// stage 4: h before the mod 30
	logic [8:0] hv_s4;
	logic [4:0] a_s4;
	logic [1:0] e_s4;
	logic [4:0] i_s4;
	logic [1:0] k_s4;

	always_ff @(posedge clk) begin
		hv_s4 <= 9'(a_s3) * 9'd19 + 9'(b_s3) + 9'd15 - 9'(d_s3) - 9'(g_s3);
		a_s4  <= a_s3;
		e_s4  <= e_s3;
		i_s4  <= i_s3;
		k_s4  <= k_s3;
	end

	// stage 5: h = hv mod 30
	logic [13:0] hp;
	logic [4:0]  hq0;
	logic [8:0]  hr0;
	logic [4:0]  h_s5;
	logic [4:0]  a_s5;
	logic [1:0]  e_s5;
	logic [4:0]  i_s5;
	logic [1:0]  k_s5;

	always_comb begin
		hp  = 14'(hv_s4) * 14'(RCP_30);
		hq0 = hp[13:9];
		hr0 = hv_s4 - 9'(hq0) * 9'd30;
	end

	always_ff @(posedge clk) begin
		h_s5 <= (hr0 >= 9'd30) ? 5'(hr0 - 9'd30) : 5'(hr0);
		a_s5 <= a_s4;
		e_s5 <= e_s4;
		i_s5 <= i_s4;
		k_s5 <= k_s4;
	end

	// stage 6: l = (32 + 2e + 2i - h - k) mod 7
	logic [6:0] lv;
	logic [9:0] lp;
	logic [3:0] lq0;
	logic [6:0] lr0;
	logic [2:0] l_s6;
	logic [4:0] h_s6;
	logic [4:0] a_s6;

	always_comb begin
		lv  = 7'd32 + {4'd0, e_s5, 1'b0} + {1'b0, i_s5, 1'b0} - 7'(h_s5) - 7'(k_s5);
		lp  = 10'(lv) * 10'(RCP_7);
		lq0 = lp[9:6];
		lr0 = lv - 7'(lq0) * 7'd7;
	end

	always_ff @(posedge clk) begin
		l_s6 <= (lr0 >= 7'd7) ? 3'(lr0 - 7'd7) : 3'(lr0);
		h_s6 <= h_s5;
		a_s6 <= a_s5;
	end

	// stage 7: m and s
	logic [8:0] mv;
	logic       m7;
	logic [7:0] s_s7;

	always_comb begin
		mv = 9'(a_s6) + 9'(h_s6) * 9'd11 + 9'(l_s6) * 9'd22;
		m7 = (mv >= M_LIM);  // quotient by 451 is 0 or 1
	end

	always_ff @(posedge clk) begin
		s_s7 <= 8'(h_s6) + 8'(l_s6) + S_OFS - (m7 ? 8'd7 : 8'd0);
	end

	// stage 8: month and day, s is always in 93..154
	logic       apr8;
	logic [7:0] ed8;

	always_comb begin
		apr8 = (s_s7 >= S_APR);
		ed8  = s_s7 - (apr8 ? S_APR : S_MAR) + 8'd1;
	end

	always_ff @(posedge clk) begin
		em <= apr8 ? EM_APR : EM_MAR;
		ed <= ed8[DAY_W-1:0];
	end

endmodule
